[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the watchdog RTL. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is low
`define HWE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hwe assertion failed");
// clocked check, also active during reset
`define HWE_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("hwe assertion failed");
`else
`define HWE_ASSERT(lbl, clk, rst_n, prop)
`define HWE_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[src/hwe_pkg.sv]
// ----------------------------------------------------------------------------
// hwe_pkg
// Types, codes and constants of the health watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package hwe_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;

    localparam int SLOT_W    = 6;
    localparam int CLASS_W   = 2;
    localparam int NOW_W     = 32;
    localparam int REG_W     = 32;
    localparam int CODE_W    = 64;
    localparam int CFG_IDX_W = 4;
    localparam int NUM_CLASS = 4;
    localparam int REG_COUNT = 2 * NUM_CLASS;

    localparam logic [REG_W-1:0] THR_RESET = REG_W'(30);
    localparam logic [REG_W-1:0] MAX_RESET = REG_W'(60);

    typedef enum logic [1:0] {
        ST_INVALID   = 2'd0,
        ST_VALID     = 2'd1,
        ST_THRESHOLD = 2'd2,
        ST_ALARMING  = 2'd3
    } t_unit_state;

    typedef enum logic [1:0] {
        TR_NONE      = 2'd0,
        TR_HEALTHY   = 2'd1,
        TR_THRESHOLD = 2'd2,
        TR_BAD       = 2'd3
    } t_trans;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_ALARM     = 2'd1,
        EV_THRESHOLD = 2'd2,
        EV_VALID     = 2'd3
    } t_event;

    typedef enum logic [CLASS_W-1:0] {
        CLS_PARTITION = 2'd0,
        CLS_NODE      = 2'd1,
        CLS_LEADER    = 2'd2,
        CLS_FAILOVER  = 2'd3
    } t_unit_class;

    // per-slot outcome of one request
    typedef struct packed {
        t_trans trans;
        logic   notify;
        logic   palarm;
        logic   thr_seen;
    } t_slot_res;

    // sweep summary, nonzero only on a sweep end
    typedef struct packed {
        logic              done;
        t_event            ev;
        logic              healthy;
        logic [CODE_W-1:0] bad;
        logic [CODE_W-1:0] still;
    } t_sweep_out;

endpackage

`default_nettype wire

[src/hwe_in_if.sv]
// ----------------------------------------------------------------------------
// hwe_in_if
// Check request channel: one monitored slot per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface hwe_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot;
    logic [1:0]  unit_class;
    logic        is_valid;
    logic [31:0] now_time;
    logic        sweep_end;

    modport source (output valid, slot, unit_class, is_valid, now_time, sweep_end,
                    input ready);
    modport sink   (input valid, slot, unit_class, is_valid, now_time, sweep_end,
                    output ready);
endinterface

`default_nettype wire

[src/hwe_out_if.sv]
// ----------------------------------------------------------------------------
// hwe_out_if
// Result channel: per-slot flags plus the sweep summary.
// ----------------------------------------------------------------------------
`default_nettype none

interface hwe_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  transition;
    logic        threshold_notify;
    logic        periodic_alarm;
    logic        sweep_done;
    logic [1:0]  monitor_event;
    logic        healthy;
    logic [63:0] bad_code;
    logic [63:0] still_bad_code;

    modport source (output valid, transition, threshold_notify, periodic_alarm,
                    sweep_done, monitor_event, healthy, bad_code, still_bad_code,
                    input ready);
    modport sink   (input valid, transition, threshold_notify, periodic_alarm,
                    sweep_done, monitor_event, healthy, bad_code, still_bad_code,
                    output ready);
endinterface

`default_nettype wire

[src/hwe_ram.sv]
// ----------------------------------------------------------------------------
// hwe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/hwe_slot_upd.sv]
// ----------------------------------------------------------------------------
// hwe_slot_upd
// Modify step of the slot read-modify-write: state move, notice and re-alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module hwe_slot_upd
    import hwe_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic [2+3*TIME_BITS-1:0] i_entry,
    input  wire logic [REG_W-1:0]         i_thr,
    input  wire logic [REG_W-1:0]         i_max,
    input  wire logic                     i_is_valid,
    input  wire logic [CLASS_W-1:0]       i_class,
    input  wire logic [TIME_BITS-1:0]     i_now,
    output logic      [2+3*TIME_BITS-1:0] o_entry,
    output t_slot_res                     o_res
);

    localparam int CW = (TIME_BITS > REG_W) ? TIME_BITS : REG_W;

    t_unit_state            prev;
    t_unit_state            st;
    logic [TIME_BITS-1:0]   lv, ln, la;
    logic [TIME_BITS-1:0]   n_lv, n_ln, n_la;
    logic [TIME_BITS-1:0]   d_valid, d_notice, d_alarm;
    logic [CW-1:0]          thr_e, max_e;
    t_trans                 trans;
    logic                   notify, palarm;

    assign prev = t_unit_state'(i_entry[3*TIME_BITS +: 2]);
    assign lv   = i_entry[2*TIME_BITS +: TIME_BITS];
    assign ln   = i_entry[TIME_BITS +: TIME_BITS];
    assign la   = i_entry[0 +: TIME_BITS];

    assign thr_e    = CW'(i_thr);
    assign max_e    = CW'(i_max);
    assign d_valid  = i_now - lv;
    assign d_notice = i_now - ln;

    always_comb begin
        st     = prev;
        n_lv   = lv;
        n_ln   = ln;
        n_la   = la;
        trans  = TR_NONE;
        notify = 1'b0;
        palarm = 1'b0;

        if (i_is_valid) begin
            st   = ST_VALID;
            n_lv = i_now;
            if (prev == ST_ALARMING || prev == ST_THRESHOLD) begin
                trans = TR_HEALTHY;
            end
        end else if (prev != ST_ALARMING) begin
            priority if (CW'(d_valid) >= max_e) begin
                st    = ST_ALARMING;
                n_la  = i_now;
                trans = TR_BAD;
            end else if (CW'(d_valid) >= thr_e) begin
                if (prev != ST_THRESHOLD) begin
                    st    = ST_THRESHOLD;
                    trans = TR_THRESHOLD;
                end
            end else begin
                st = ST_INVALID;
            end
        end

        // re-alarm period counts from the alarm time just written
        d_alarm = i_now - n_la;

        if (st == ST_THRESHOLD || st == ST_ALARMING) begin
            if (CW'(d_notice) >= thr_e) begin
                notify = 1'b1;
                n_ln   = i_now;
            end
            if (st == ST_ALARMING && CW'(d_alarm) >= max_e) begin
                palarm = 1'b1;
                n_la   = i_now;
            end
        end
    end

    assign o_entry        = {st, n_lv, n_ln, n_la};
    assign o_res.trans    = trans;
    assign o_res.notify   = notify;
    assign o_res.palarm   = palarm;
    assign o_res.thr_seen = (trans == TR_THRESHOLD) && (i_class >= CLS_LEADER);

endmodule

`default_nettype wire

[src/hwe_sweep.sv]
// ----------------------------------------------------------------------------
// hwe_sweep
// Sweep accumulators and the global escalation flags.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hwe_sweep
    import hwe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic              i_active,
    input  wire logic              i_is_valid,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire t_slot_res         i_res,
    input  wire logic              i_sweep_end,
    output t_sweep_out             o_sweep
);

    logic              r_healthy, n_healthy;
    logic [CODE_W-1:0] r_bad, n_bad;
    logic [CODE_W-1:0] r_still, n_still;
    logic              r_seen, n_seen;
    logic              r_alarmed, n_alarmed;
    logic              r_thr_flag, n_thr_flag;
    logic [CODE_W-1:0] bit_mask;
    t_event            ev;

    assign bit_mask = CODE_W'(1) << i_slot;

    always_comb begin
        n_healthy  = r_healthy & ~(i_active & ~i_is_valid);
        n_bad      = r_bad | ((i_active && i_res.trans == TR_BAD) ? bit_mask : '0);
        n_still    = r_still | ((i_active && i_res.palarm) ? bit_mask : '0);
        n_seen     = r_seen | (i_active & i_res.thr_seen);
        n_alarmed  = r_alarmed;
        n_thr_flag = r_thr_flag;
        ev         = EV_NONE;

        priority if (n_bad != '0 && !r_alarmed) begin
            n_alarmed = 1'b1;
            ev        = EV_ALARM;
        end else if (n_seen && !r_alarmed && !r_thr_flag) begin
            n_thr_flag = 1'b1;
            ev         = EV_THRESHOLD;
        end else if (n_healthy && (r_alarmed || r_thr_flag)) begin
            n_alarmed  = 1'b0;
            n_thr_flag = 1'b0;
            ev         = EV_VALID;
        end else begin
            ev = EV_NONE;
        end

        if (i_step && i_sweep_end) begin
            o_sweep.done    = 1'b1;
            o_sweep.ev      = ev;
            o_sweep.healthy = n_healthy;
            o_sweep.bad     = n_bad;
            o_sweep.still   = n_still;
        end else begin
            o_sweep = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_healthy  <= 1'b1;
            r_bad      <= '0;
            r_still    <= '0;
            r_seen     <= 1'b0;
            r_alarmed  <= 1'b0;
            r_thr_flag <= 1'b0;
        end else if (i_step) begin
            if (i_sweep_end) begin
                r_healthy  <= 1'b1;
                r_bad      <= '0;
                r_still    <= '0;
                r_seen     <= 1'b0;
                r_alarmed  <= n_alarmed;
                r_thr_flag <= n_thr_flag;
            end else begin
                r_healthy <= n_healthy;
                r_bad     <= n_bad;
                r_still   <= n_still;
                r_seen    <= n_seen;
            end
        end
    end

    `HWE_ASSERT(a_sweep_clears, i_clk, i_rst_n, (i_step && i_sweep_end) |=> (r_healthy && r_bad == '0 && r_still == '0 && !r_seen))
    `HWE_ASSERT(a_alarm_has_code, i_clk, i_rst_n, (o_sweep.ev == EV_ALARM) |-> (o_sweep.bad != '0))
    `HWE_ASSERT_NR(a_valid_is_healthy, i_clk, (o_sweep.ev == EV_VALID) |-> o_sweep.healthy)

endmodule

`default_nettype wire

[src/health_watchdog_escalation.sv]
// ----------------------------------------------------------------------------
// health_watchdog_escalation
// Per-slot health watchdog with threshold notices and alarm escalation.
//
//   channel   dir  handshake      contents
//   i_in      in   valid/ready    slot, unit_class, is_valid, now_time, sweep_end
//   o_out     out  valid/ready    per-slot flags, sweep summary
//   i_cfg_*   in   write enable   8 timing registers, 32 bits
//
// One request per cycle sustained unless the output stalls; results are held in
// the output register. Slot state sits in one RAM (read at accept, written back
// as the request stage advances); a back-to-back request to the same slot uses
// the forward register. Reset loads default timings and clears per-entry valid
// bits. A stalled output holds the stage behind it, then ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module health_watchdog_escalation
    import hwe_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    hwe_in_if.sink                    i_in,
    hwe_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_data
);

    localparam int AW    = $clog2(SLOTS);
    localparam int ENT_W = 2 + 3 * TIME_BITS;

    // configuration
    logic [REG_W-1:0] r_thr [NUM_CLASS];
    logic [REG_W-1:0] r_max [NUM_CLASS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASS; c++) begin
                r_thr[c] <= THR_RESET;
                r_max[c] <= MAX_RESET;
            end
        end else if (i_cfg_we && i_cfg_idx < CFG_IDX_W'(REG_COUNT)) begin
            if (i_cfg_idx[0]) begin
                r_max[i_cfg_idx[2:1]] <= i_cfg_data;
            end else begin
                r_thr[i_cfg_idx[2:1]] <= i_cfg_data;
            end
        end
    end

    // request stage
    logic               r_s1_vld;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic [CLASS_W-1:0] r_s1_cls;
    logic               r_s1_is_valid;
    logic [NOW_W-1:0]   r_s1_now;
    logic               r_s1_end;
    logic [AW-1:0]      r_s1_addr;

    logic accept, load_ok, advance, s1_active;

    assign load_ok   = !o_out.valid || o_out.ready;
    assign advance   = r_s1_vld && load_ok;
    assign i_in.ready = !r_s1_vld || load_ok;
    assign accept    = i_in.valid && i_in.ready;
    assign r_s1_addr = r_s1_slot[AW-1:0];
    assign s1_active = {1'b0, r_s1_slot} < (SLOT_W+1)'(SLOTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (advance) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_slot     <= i_in.slot;
            r_s1_cls      <= i_in.unit_class;
            r_s1_is_valid <= i_in.is_valid;
            r_s1_now      <= i_in.now_time;
            r_s1_end      <= i_in.sweep_end;
        end
    end

    // slot store, valid bits, forwarding
    logic [ENT_W-1:0] rd_data, cur_entry, n_entry;
    logic             ram_we;
    logic [SLOTS-1:0] r_ent_vld;
    logic             r_fwd_vld;
    logic [AW-1:0]    r_fwd_addr;
    logic [ENT_W-1:0] r_fwd_data;

    assign ram_we = advance && s1_active;

    hwe_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_entry),
        .i_re    (accept),
        .i_raddr (i_in.slot[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_fwd_vld <= 1'b0;
        end else if (ram_we) begin
            r_ent_vld[r_s1_addr] <= 1'b1;
            r_fwd_vld            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_entry;
        end
    end

    // last write is the newest copy of its slot; unwritten entries read as reset
    always_comb begin
        priority if (r_fwd_vld && r_fwd_addr == r_s1_addr) begin
            cur_entry = r_fwd_data;
        end else if (r_ent_vld[r_s1_addr]) begin
            cur_entry = rd_data;
        end else begin
            cur_entry = '0;
        end
    end

    t_slot_res  slot_res;
    t_sweep_out sweep;

    hwe_slot_upd #(
        .TIME_BITS (TIME_BITS)
    ) u_upd (
        .i_entry    (cur_entry),
        .i_thr      (r_thr[r_s1_cls]),
        .i_max      (r_max[r_s1_cls]),
        .i_is_valid (r_s1_is_valid),
        .i_class    (r_s1_cls),
        .i_now      (TIME_BITS'(r_s1_now)),
        .o_entry    (n_entry),
        .o_res      (slot_res)
    );

    hwe_sweep u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_active    (s1_active),
        .i_is_valid  (r_s1_is_valid),
        .i_slot      (r_s1_slot),
        .i_res       (slot_res),
        .i_sweep_end (r_s1_end),
        .o_sweep     (sweep)
    );

    // output register
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    logic [1:0]        r_transition;
    logic              r_notify, r_palarm, r_done, r_healthy;
    logic [1:0]        r_event;
    logic [CODE_W-1:0] r_bad, r_still;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_transition <= s1_active ? slot_res.trans : TR_NONE;
            r_notify     <= s1_active & slot_res.notify;
            r_palarm     <= s1_active & slot_res.palarm;
            r_done       <= sweep.done;
            r_event      <= sweep.ev;
            r_healthy    <= sweep.healthy;
            r_bad        <= sweep.bad;
            r_still      <= sweep.still;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.transition       = r_transition;
    assign o_out.threshold_notify = r_notify;
    assign o_out.periodic_alarm   = r_palarm;
    assign o_out.sweep_done       = r_done;
    assign o_out.monitor_event    = r_event;
    assign o_out.healthy          = r_healthy;
    assign o_out.bad_code         = r_bad;
    assign o_out.still_bad_code   = r_still;

    `HWE_ASSERT(a_write_marks_entry, i_clk, i_rst_n, ram_we |=> r_ent_vld[$past(r_s1_addr)])
    `HWE_ASSERT(a_stall_holds_stage, i_clk, i_rst_n, (r_s1_vld && !load_ok) |=> (r_s1_vld && $stable(r_s1_slot)))
    `HWE_ASSERT(a_advance_fills_out, i_clk, i_rst_n, advance |=> r_out_vld)

endmodule

`default_nettype wire
